[rtl/ordered_unique_set_table_assert.svh]
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ORDERED_UNIQUE_SET_TABLE_ASSERT_SVH
`define ORDERED_UNIQUE_SET_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OUST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OUST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/oust_pkg.sv]
`default_nettype none
package oust_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_FIND   = 2'd1;
    localparam logic [1:0] REQ_ERASE  = 2'd2;

    localparam int POS_W = 12;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] element;
    } req_t;

    typedef struct packed {
        logic       found;
        logic [5:0] position;
        logic [6:0] entry_count;
        logic       is_empty;
        logic       overflow;
    } result_t;

    typedef struct packed {
        logic             active;
        logic             hit;
        logic [POS_W-1:0] pos;
    } token_t;

endpackage
`default_nettype wire

[rtl/oust_cell.sv]
`default_nettype none
module oust_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire oust_pkg::token_t  tok_i,
    output oust_pkg::token_t       tok_o,
    input  wire oust_pkg::req_t    req_i,
    input  wire logic [CNT_W-1:0]  count_i,
    input  wire logic [31:0]       next_entry_i,
    input  wire logic              next_shift_i,
    output logic [31:0]            entry_o,
    output logic                   shift_o
);

    oust_pkg::token_t tok_reg;
    logic [31:0]      entry_reg;
    logic             valid;
    logic             match;
    logic             ins_here;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg.active <= tok_i.active;
        end
        tok_reg.hit <= tok_i.hit;
        tok_reg.pos <= tok_i.pos;
    end

    assign valid = CNT_W'(IDX) < count_i;
    assign match = tok_reg.active && valid && !tok_reg.hit
                   && (entry_reg == $unsigned(req_i.element));
    assign ins_here = tok_reg.active && !tok_reg.hit
                      && (req_i.req_type == oust_pkg::REQ_INSERT)
                      && (CNT_W'(IDX) == count_i);

    always_ff @(posedge aclk) begin
        if (next_shift_i) begin
            entry_reg <= next_entry_i;
        end else if (ins_here) begin
            entry_reg <= $unsigned(req_i.element);
        end
    end

    always_comb begin
        tok_o        = tok_reg;
        tok_o.hit    = tok_reg.hit || match;
        tok_o.pos    = match ? oust_pkg::POS_W'(IDX) : tok_reg.pos;
    end

    assign shift_o = tok_reg.active && tok_reg.hit
                     && (req_i.req_type == oust_pkg::REQ_ERASE);
    assign entry_o = entry_reg;

endmodule
`default_nettype wire

[rtl/ordered_unique_set_table.sv]
`default_nettype none
// Ordered set of up to CAPACITY unique 32-bit values kept in insertion order.
// Each request (insert, find or erase) is carried by a token that walks the
// row of cells one cell per cycle; every cell compares its stored value as the
// token passes, an insert lands in the first free cell, and an erase moves each
// later value one cell down behind the token. A result goes from the last cell
// into a done register and then into the output register, and a new request is
// accepted only once the result of the last one has moved into the output
// register, so one request at a time walks the cell row. A result waiting in
// the output register does not block the next request, but the result of that
// request then holds the input off until the output register is free. There is
// no clearing pass after reset.
`include "ordered_unique_set_table_assert.svh"
module ordered_unique_set_table #(
    parameter int CAPACITY = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire oust_pkg::req_t   s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output oust_pkg::result_t     m_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    oust_pkg::token_t  tok_w [0:CAPACITY];
    logic [31:0]       entry_w [0:CAPACITY];
    logic              shift_w [0:CAPACITY];

    oust_pkg::req_t    req_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              busy_reg;
    logic              done_valid_reg;
    oust_pkg::result_t done_reg;
    oust_pkg::result_t done_next;
    logic              m_valid_reg;
    oust_pkg::result_t m_data_reg;
    logic              accept;
    logic              finish;
    logic              move_out;
    logic              full;
    logic              is_ins;
    logic              is_era;
    logic [CNT_W+6:0]  cnt_ext;

    assign accept   = s_valid && s_ready;
    assign finish   = tok_w[CAPACITY].active;
    assign move_out = done_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !busy_reg;

    assign tok_w[0] = '{active: accept, hit: 1'b0, pos: '0};

    assign entry_w[CAPACITY] = '0;
    assign shift_w[CAPACITY] = 1'b0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        oust_cell #(
            .IDX   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .tok_i        (tok_w[k]),
            .tok_o        (tok_w[k+1]),
            .req_i        (req_reg),
            .count_i      (count_reg),
            .next_entry_i (entry_w[k+1]),
            .next_shift_i (shift_w[k+1]),
            .entry_o      (entry_w[k]),
            .shift_o      (shift_w[k])
        );
    end

    assign full   = count_reg == CNT_W'(CAPACITY);
    assign is_ins = req_reg.req_type == oust_pkg::REQ_INSERT;
    assign is_era = req_reg.req_type == oust_pkg::REQ_ERASE;

    always_comb begin
        count_next = count_reg;
        if (is_ins && !tok_w[CAPACITY].hit && !full) begin
            count_next = count_reg + CNT_W'(1);
        end else if (is_era && tok_w[CAPACITY].hit) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign cnt_ext = {7'b0, count_next};

    always_comb begin
        done_next.found       = tok_w[CAPACITY].hit;
        done_next.position    = tok_w[CAPACITY].pos[5:0];
        done_next.entry_count = cnt_ext[6:0];
        done_next.is_empty    = count_next == '0;
        done_next.overflow    = is_ins && !tok_w[CAPACITY].hit && full;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_data;
        end
        if (finish) begin
            done_reg <= done_next;
        end
        if (move_out) begin
            m_data_reg <= done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            busy_reg       <= 1'b0;
            done_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (finish) begin
                count_reg <= count_next;
            end
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (move_out) begin
                busy_reg <= 1'b0;
            end
            if (finish) begin
                done_valid_reg <= 1'b1;
            end else if (move_out) begin
                done_valid_reg <= 1'b0;
            end
            if (move_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `OUST_ASSERT_IMP(a_done_only_busy, done_valid_reg, busy_reg, "result pending while idle")
    `OUST_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `OUST_ASSERT_IMP(a_ovf_not_found, m_valid && m_data.overflow, !m_data.found, "overflow with a hit")
    `OUST_ASSERT_NXT(a_accept_blocks, accept, !s_ready, "ready right after a request")

endmodule
`default_nettype wire
